### hw/rtl/ac_ir_frame_transmitter_top_assert.svh
// Assertion macros used by the checker file of the infrared transmitter.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef AC_IR_FRAME_TRANSMITTER_TOP_ASSERT_SVH
`define AC_IR_FRAME_TRANSMITTER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACIR_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ACIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/acir_pkg.sv
`default_nettype none

package acir_pkg;

    localparam int FRAME_WORDS = 6;
    localparam int NUM_REGS    = 8;
    localparam int REG_W       = 16;
    localparam int WORD_W      = 16;

    localparam logic [5:0] MIN_TEMP = 6'd16;
    localparam logic [5:0] MAX_TEMP = 6'd31;

    localparam logic [5:0] CODE_TEMP_LO = 6'd16;
    localparam logic [5:0] CODE_TEMP_HI = 6'd31;

    localparam logic [15:0] WORD_PREAMBLE = 16'hFF00;
    localparam logic [15:0] WORD_TOGGLE   = 16'hFF00;
    localparam logic [15:0] WORD_STEADY   = 16'h7F80;
    localparam logic [15:0] WORD_FOOTER   = 16'h54AB;

    localparam logic [7:0] PS_ON_FIXED   = 8'hB4;
    localparam logic [7:0] PS_ON_SWING   = 8'hA5;
    localparam logic [7:0] PS_OFF_FIXED  = 8'hF0;
    localparam logic [7:0] PS_OFF_SWING  = 8'hE1;
    localparam logic [7:0] MODE_CODE_OFF = 8'hB4;

    localparam logic [2:0] MODE_OFF  = 3'd0;
    localparam logic [2:0] MODE_COOL = 3'd2;
    localparam logic [2:0] MODE_FAN  = 3'd5;

    // Configuration register indexes.
    localparam logic [2:0] REG_HEADER_MARK  = 3'd0;
    localparam logic [2:0] REG_HEADER_SPACE = 3'd1;
    localparam logic [2:0] REG_BIT_MARK     = 3'd2;
    localparam logic [2:0] REG_ONE_SPACE    = 3'd3;
    localparam logic [2:0] REG_ZERO_SPACE   = 3'd4;
    localparam logic [2:0] REG_FOOTER_MARK1 = 3'd5;
    localparam logic [2:0] REG_FOOTER_GAP   = 3'd6;
    localparam logic [2:0] REG_FOOTER_MARK2 = 3'd7;

    localparam logic [NUM_REGS-1:0][REG_W-1:0] REG_RESET = {
        16'd616, 16'd7372, 16'd608, 16'd1600, 16'd3600, 16'd608, 16'd7392, 16'd6234
    };

    localparam logic REQ_CONTROL = 1'b0;
    localparam logic REQ_TICK    = 1'b1;

    typedef struct packed {
        logic [2:0] mode_in;
        logic       has_mode;
        logic       swing_in;
        logic       has_swing;
        logic [1:0] fan_in;
        logic       has_fan;
        logic [5:0] temp_in;
        logic       has_temp;
    } ctrl_fields_t;

    typedef struct packed {
        logic                              start;
        logic [FRAME_WORDS-1:0][WORD_W-1:0] words;
    } frame_req_t;

    typedef struct packed {
        logic led_on;
        logic busy;
        logic started;
        logic rejected;
    } env_status_t;

    typedef struct packed {
        logic       we;
        logic [2:0] addr;
        logic [15:0] data;
    } cfg_write_t;

    function automatic logic [7:0] temp_code(input logic [3:0] idx);
        logic [7:0] code;
        case (idx)
            4'd0:    code = 8'hF0;
            4'd1:    code = 8'h78;
            4'd2:    code = 8'hB4;
            4'd3:    code = 8'h3C;
            4'd4:    code = 8'hD2;
            4'd5:    code = 8'h5A;
            4'd6:    code = 8'h96;
            4'd7:    code = 8'h1E;
            4'd8:    code = 8'hE1;
            4'd9:    code = 8'h69;
            4'd10:   code = 8'hA5;
            4'd11:   code = 8'h2D;
            4'd12:   code = 8'hC3;
            4'd13:   code = 8'h4B;
            4'd14:   code = 8'h87;
            default: code = 8'h0F;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] mode_code(input logic [2:0] mode);
        logic [7:0] code;
        case (mode)
            3'd1:    code = 8'hF0;
            3'd3:    code = 8'hE1;
            3'd4:    code = 8'hD2;
            3'd5:    code = 8'h96;
            default: code = 8'hB4;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] fan_code(input logic [1:0] fan);
        logic [7:0] code;
        case (fan)
            2'd0:    code = 8'hF0;
            2'd1:    code = 8'h96;
            2'd2:    code = 8'hD2;
            default: code = 8'hB4;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/acir_settings.sv
`default_nettype none

module acir_settings (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 ctrl_fire,
    input  wire acir_pkg::ctrl_fields_t fields,
    output acir_pkg::frame_req_t      req,
    output logic                      power_on,
    output logic [5:0]                set_temp
);
    import acir_pkg::*;

    logic       power_reg;
    logic [2:0] mode_reg;
    logic [1:0] fan_reg;
    logic       swing_reg;
    logic [5:0] temp_reg;

    logic       power_next;
    logic [2:0] mode_next;
    logic [1:0] fan_next;
    logic       swing_next;
    logic [5:0] temp_next;
    logic       send;
    logic       toggle;
    logic [2:0] mode_req;
    logic [5:0] code_temp;
    logic [7:0] ps_code;
    logic [7:0] mcode;

    always_comb
    begin
        power_next = power_reg;
        mode_next  = mode_reg;
        fan_next   = fan_reg;
        swing_next = swing_reg;
        temp_next  = temp_reg;
        send       = 1'b0;
        toggle     = 1'b0;
        mode_req   = (fields.mode_in > MODE_FAN) ? MODE_COOL : fields.mode_in;

        if (fields.has_temp)
        begin
            if (fields.temp_in < MIN_TEMP)
                temp_next = MIN_TEMP;
            else if (fields.temp_in > MAX_TEMP)
                temp_next = MAX_TEMP;
            else
                temp_next = fields.temp_in;
            send = 1'b1;
        end
        if (fields.has_fan)
        begin
            fan_next = fields.fan_in;
            send     = 1'b1;
        end
        if (fields.has_swing)
        begin
            swing_next = fields.swing_in;
            send       = 1'b1;
        end
        if (fields.has_mode)
        begin
            if (mode_req == MODE_OFF)
            begin
                if (power_reg)
                begin
                    toggle     = 1'b1;
                    power_next = 1'b0;
                    send       = 1'b1;
                end
            end
            else
            begin
                if (!power_reg)
                begin
                    toggle     = 1'b1;
                    power_next = 1'b1;
                end
                mode_next = mode_req;
                send      = 1'b1;
            end
        end

        if (temp_next < CODE_TEMP_LO)
            code_temp = CODE_TEMP_LO;
        else if (temp_next > CODE_TEMP_HI)
            code_temp = CODE_TEMP_HI;
        else
            code_temp = temp_next;

        if (power_next)
            ps_code = swing_next ? PS_ON_SWING : PS_ON_FIXED;
        else
            ps_code = swing_next ? PS_OFF_SWING : PS_OFF_FIXED;
        mcode = power_next ? mode_code(mode_next) : MODE_CODE_OFF;
    end

    assign req.start    = ctrl_fire && send;
    assign req.words[0] = WORD_PREAMBLE;
    assign req.words[1] = WORD_PREAMBLE;
    assign req.words[2] = toggle ? WORD_TOGGLE : WORD_STEADY;
    assign req.words[3] = {ps_code, fan_code(fan_next)};
    assign req.words[4] = {temp_code(4'(code_temp - CODE_TEMP_LO)), mcode};
    assign req.words[5] = WORD_FOOTER;

    assign power_on = ctrl_fire ? power_next : power_reg;
    assign set_temp = ctrl_fire ? temp_next : temp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg <= 1'b0;
            mode_reg  <= MODE_COOL;
            fan_reg   <= 2'd0;
            swing_reg <= 1'b0;
            temp_reg  <= 6'd24;
        end
        else if (ctrl_fire)
        begin
            power_reg <= power_next;
            mode_reg  <= mode_next;
            fan_reg   <= fan_next;
            swing_reg <= swing_next;
            temp_reg  <= temp_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/acir_envelope.sv
`default_nettype none

module acir_envelope (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire logic                req_type,
    input  wire acir_pkg::frame_req_t req,
    input  wire acir_pkg::cfg_write_t cfg,
    output logic                     idle,
    output acir_pkg::env_status_t    status
);
    import acir_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_HMARK, PH_HSPACE, PH_BMARK, PH_BSPACE, PH_FMARK1, PH_FGAP, PH_FMARK2
    } phase_t;

    localparam logic [6:0] LAST_BIT = 7'(FRAME_WORDS * WORD_W - 1);

    phase_t                  phase_reg, phase_next;
    logic [6:0]              bit_pos_reg, bit_pos_next;
    logic [REG_W-1:0]        seg_left_reg, seg_left_next;
    logic [REG_W-1:0]        cfg_reg [NUM_REGS];
    logic [WORD_W-1:0]       words_reg [FRAME_WORDS];
    logic                    level;
    logic                    cur_bit;
    logic [2:0]              word_idx;

    assign idle     = (phase_reg == PH_IDLE);
    assign word_idx = bit_pos_reg[6:4];
    assign level    = (phase_reg == PH_HMARK) || (phase_reg == PH_BMARK) ||
                      (phase_reg == PH_FMARK1) || (phase_reg == PH_FMARK2);

    always_comb
    begin
        if (word_idx < 3'(FRAME_WORDS))
            cur_bit = words_reg[word_idx][4'd15 - bit_pos_reg[3:0]];
        else
            cur_bit = 1'b0;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        bit_pos_next   = bit_pos_reg;
        seg_left_next  = seg_left_reg;
        status         = '0;

        if (fire && (req_type == REQ_TICK))
        begin
            if (!idle)
            begin
                status.led_on = level;
                status.busy   = 1'b1;
                if (seg_left_reg > 16'd1)
                    seg_left_next = seg_left_reg - 16'd1;
                else
                begin
                    case (phase_reg)
                        PH_HMARK:
                        begin
                            phase_next    = PH_HSPACE;
                            seg_left_next = cfg_reg[REG_HEADER_SPACE];
                        end
                        PH_HSPACE:
                        begin
                            bit_pos_next  = '0;
                            phase_next    = PH_BMARK;
                            seg_left_next = cfg_reg[REG_BIT_MARK];
                        end
                        PH_BMARK:
                        begin
                            phase_next    = PH_BSPACE;
                            seg_left_next = cur_bit ? cfg_reg[REG_ONE_SPACE]
                                                    : cfg_reg[REG_ZERO_SPACE];
                        end
                        PH_BSPACE:
                        begin
                            if (bit_pos_reg >= LAST_BIT)
                            begin
                                phase_next    = PH_FMARK1;
                                seg_left_next = cfg_reg[REG_FOOTER_MARK1];
                            end
                            else
                            begin
                                bit_pos_next  = bit_pos_reg + 7'd1;
                                phase_next    = PH_BMARK;
                                seg_left_next = cfg_reg[REG_BIT_MARK];
                            end
                        end
                        PH_FMARK1:
                        begin
                            phase_next    = PH_FGAP;
                            seg_left_next = cfg_reg[REG_FOOTER_GAP];
                        end
                        PH_FGAP:
                        begin
                            phase_next    = PH_FMARK2;
                            seg_left_next = cfg_reg[REG_FOOTER_MARK2];
                        end
                        default:
                        begin
                            phase_next    = PH_IDLE;
                            seg_left_next = '0;
                            bit_pos_next  = '0;
                        end
                    endcase
                end
            end
        end
        else if (fire)
        begin
            if (!idle)
            begin
                status.rejected = 1'b1;
                status.busy     = 1'b1;
                status.led_on   = level;
            end
            else if (req.start)
            begin
                bit_pos_next   = '0;
                phase_next     = PH_HMARK;
                seg_left_next  = cfg_reg[REG_HEADER_MARK];
                status.started = 1'b1;
                status.busy    = 1'b1;
                status.led_on  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            bit_pos_reg  <= '0;
            seg_left_reg <= '0;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= REG_RESET[i];
            end
        end
        else
        begin
            phase_reg    <= phase_next;
            bit_pos_reg  <= bit_pos_next;
            seg_left_reg <= seg_left_next;
            if (cfg.we)
                cfg_reg[cfg.addr] <= cfg.data;
        end
    end

    // The frame buffer holds the whole frame and is always written before it is read.
    always_ff @(posedge clk)
    begin
        if (fire && (req_type == REQ_CONTROL) && idle && req.start)
        begin
            for (int i = 0; i < FRAME_WORDS; i++)
            begin
                words_reg[i] <= req.words[i];
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ac_ir_frame_transmitter_top.sv
// Infrared remote transmitter for an air conditioner, envelope level only.
// Input stream: tuser carries the kind of beat (0 control, 1 one-microsecond
// tick); tdata carries the control fields. Output stream: one result beat for
// every input beat, in order, with the envelope level and status flags.
// Configuration: cfg_we, cfg_addr and cfg_wdata write the eight segment
// length registers (header mark and space, bit mark, one and zero space,
// footer marks and gap); they are to be written only while the block is idle,
// which the block does not enforce. An accepted beat goes through the input
// register and then the result register. Throughput is one beat per cycle
// while the receiver does not stall; the settings update and envelope step
// are each a single pass of logic between these two registers.
// A stalled receiver holds the result register, and s_tready then falls once
// the input register is also full; no beat is dropped.
// Reset restores the default segment lengths, power off, cool mode, auto fan,
// swing off, 24 degrees, and leaves both registers empty.
`default_nettype none

module ac_ir_frame_transmitter_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // has_temp, temp_in[5:0], has_fan, fan_in[1:0], has_swing, swing_in,
    // has_mode, mode_in[2:0]
    input  wire logic [15:0] s_tdata,
    // req_type
    input  wire logic [0:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // led_on, busy_res, frame_started, rejected, power_on, set_temp[5:0], zero fill
    output logic [15:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata
);
    import acir_pkg::*;

    logic               in_valid_reg;
    logic               in_type_reg;
    ctrl_fields_t       in_fields_reg;
    logic               out_valid_reg;
    logic [15:0]        out_data_reg;

    logic               fire;
    logic               ctrl_fire;
    logic               env_idle;
    frame_req_t         req;
    env_status_t        status;
    cfg_write_t         cfg;
    logic               power_on;
    logic [5:0]         set_temp;

    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign ctrl_fire = fire && (in_type_reg == REQ_CONTROL) && env_idle;

    assign cfg.we   = cfg_we;
    assign cfg.addr = cfg_addr;
    assign cfg.data = cfg_wdata;

    acir_settings u_settings (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl_fire (ctrl_fire),
        .fields    (in_fields_reg),
        .req       (req),
        .power_on  (power_on),
        .set_temp  (set_temp)
    );

    acir_envelope u_envelope (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .req_type (in_type_reg),
        .req      (req),
        .cfg      (cfg),
        .idle     (env_idle),
        .status   (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (fire)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_type_reg   <= s_tuser[0];
            in_fields_reg <= ctrl_fields_t'(s_tdata);
        end
        if (fire)
        begin
            out_data_reg <= {5'd0, set_temp, power_on, status.rejected, status.started,
                             status.busy, status.led_on};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

### hw/rtl/acir_checker.sv
`default_nettype none
`include "ac_ir_frame_transmitter_top_assert.svh"

module acir_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);

    `ACIR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result beat dropped while stalled")
    `ACIR_ASSERT_SAME(a_start_xor_reject, m_tvalid, !(m_tdata[2] && m_tdata[3]), "started and rejected together")
    `ACIR_ASSERT_SAME(a_start_busy_mark, m_tvalid && m_tdata[2], m_tdata[1] && m_tdata[0] && m_tdata[4] == m_tdata[4], "new frame not busy with mark")
    `ACIR_ASSERT_SAME(a_reject_busy, m_tvalid && m_tdata[3], m_tdata[1], "rejected beat not flagged busy")
    `ACIR_ASSERT_SAME(a_temp_range, m_tvalid, m_tdata[10:5] >= 6'd16 && m_tdata[10:5] <= 6'd31 || m_tdata[10:5] == 6'd24, "stored temperature out of range")

endmodule

bind ac_ir_frame_transmitter_top acir_checker u_acir_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
